### design/utf8vt_pkg.sv
`default_nettype none

package utf8vt_pkg;

	// Reset value of the byte limit.
	localparam logic [15:0] MAX_BYTES_RESET = 16'd123;

	// Default depth of the queue between the checking and emitting parts.
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// Stop cause codes carried on end items.
	localparam logic [1:0] CAUSE_KEPT    = 2'd0;
	localparam logic [1:0] CAUSE_INVALID = 2'd1;
	localparam logic [1:0] CAUSE_LIMIT   = 2'd2;

	// One input item: a byte of the text and its end mark.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in;
	} utf8vt_in_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       end_of_output;
		logic [1:0] stop_cause;
	} utf8vt_out_t;

	// Everything one accepted item causes: up to four bytes, then an optional end item.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      nbytes;
		logic            has_end;
		logic [1:0]      cause;
	} utf8vt_action_t;

	// Expected sequence length for a lead byte, zero if it cannot start a sequence.
	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if (b <= 8'h7F) begin
			len = 3'd1;
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			len = 3'd2;
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			len = 3'd3;
		end else if (b >= 8'hF0 && b <= 8'hF4) begin
			len = 3'd4;
		end
		return len;
	endfunction

	// Checks a continuation byte; the second byte has narrower ranges after some leads.
	function automatic logic follower_ok(input logic [7:0] lead, input logic [1:0] pos,
			input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'h80;
		hi = 8'hBF;
		if (pos == 2'd1) begin
			if (lead == 8'hE0) begin
				lo = 8'hA0;
			end else if (lead == 8'hED) begin
				hi = 8'h9F;
			end else if (lead == 8'hF0) begin
				lo = 8'h90;
			end else if (lead == 8'hF4) begin
				hi = 8'h8F;
			end
		end
		return ((b & 8'hC0) == 8'h80) && (b >= lo) && (b <= hi);
	endfunction

endpackage

`default_nettype wire

### design/utf8vt_front.sv
`default_nettype none

module utf8vt_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire utf8vt_pkg::utf8vt_in_t   item,
	input  wire logic                     push,
	input  wire logic                     cfg_wr_en,
	input  wire logic [15:0]              cfg_wr_data,
	input  wire logic                     q_full,
	output utf8vt_pkg::utf8vt_action_t    act,
	output logic                          act_push
);

	logic        accept;
	logic        stopped_q;
	logic [1:0]  pcnt_q;
	logic [2:0]  slen_q;
	logic [15:0] emit_q;
	logic [15:0] max_bytes_q;
	logic [7:0]  pend_q [3];

	logic [2:0]  lead_len;
	logic [2:0]  len_eff;
	logic        bad;
	logic [16:0] sum;

	logic        n_stopped;
	logic [1:0]  n_pcnt;
	logic [2:0]  n_slen;
	logic [15:0] n_emit;
	logic        store_pend;

	assign accept = push && !q_full;

	// Classification of the incoming byte against the held sequence.
	assign lead_len = utf8vt_pkg::lead_length(item.data_byte);
	assign len_eff  = (pcnt_q == 2'd0) ? lead_len : slen_q;
	assign bad      = (pcnt_q == 2'd0) ? (lead_len == 3'd0)
			: !utf8vt_pkg::follower_ok(pend_q[0], pcnt_q, item.data_byte);
	assign sum      = {1'b0, emit_q} + {14'd0, len_eff};

	// Next state and the action that the byte causes.
	always_comb begin
		n_stopped   = stopped_q;
		n_pcnt      = pcnt_q;
		n_slen      = slen_q;
		n_emit      = emit_q;
		store_pend  = 1'b0;
		act.bytes   = {item.data_byte, pend_q[2], pend_q[1], pend_q[0]};
		act.bytes[pcnt_q] = item.data_byte;
		act.nbytes  = 3'd0;
		act.has_end = 1'b0;
		act.cause   = utf8vt_pkg::CAUSE_KEPT;
		if (stopped_q) begin
			// Bytes are dropped until the end of the text.
		end else if (bad) begin
			act.has_end = 1'b1;
			act.cause   = utf8vt_pkg::CAUSE_INVALID;
			n_stopped   = 1'b1;
		end else if ({1'b0, pcnt_q} + 3'd1 < len_eff) begin
			// Sequence still unfinished: hold the byte.
			store_pend = 1'b1;
			n_pcnt     = pcnt_q + 2'd1;
			n_slen     = len_eff;
			if (item.last_in) begin
				act.has_end = 1'b1;
				act.cause   = utf8vt_pkg::CAUSE_INVALID;
			end
		end else if (sum > {1'b0, max_bytes_q}) begin
			act.has_end = 1'b1;
			act.cause   = utf8vt_pkg::CAUSE_LIMIT;
			n_stopped   = 1'b1;
			n_slen      = len_eff;
		end else begin
			// Complete sequence that fits: emit it whole.
			act.nbytes = {1'b0, pcnt_q} + 3'd1;
			n_emit     = sum[15:0];
			n_pcnt     = 2'd0;
			n_slen     = 3'd0;
			if (item.last_in) begin
				act.has_end = 1'b1;
				act.cause   = utf8vt_pkg::CAUSE_KEPT;
			end
		end
		// The last byte always re-arms for the next text.
		if (item.last_in) begin
			n_stopped = 1'b0;
			n_pcnt    = 2'd0;
			n_slen    = 3'd0;
			n_emit    = 16'd0;
		end
	end

	assign act_push = accept && (act.has_end || (act.nbytes != 3'd0));

	// Per-text state and the limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q   <= 1'b0;
			pcnt_q      <= 2'd0;
			slen_q      <= 3'd0;
			emit_q      <= 16'd0;
			max_bytes_q <= utf8vt_pkg::MAX_BYTES_RESET;
		end else begin
			if (accept) begin
				stopped_q <= n_stopped;
				pcnt_q    <= n_pcnt;
				slen_q    <= n_slen;
				emit_q    <= n_emit;
			end
			if (cfg_wr_en) begin
				max_bytes_q <= cfg_wr_data;
			end
		end
	end

	// Held bytes of an unfinished sequence.
	always_ff @(posedge clk) begin
		if (accept && store_pend) begin
			pend_q[pcnt_q] <= item.data_byte;
		end
	end

endmodule

`default_nettype wire

### design/utf8vt_queue.sv
`default_nettype none

module utf8vt_queue #(
	parameter int DEPTH = utf8vt_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire utf8vt_pkg::utf8vt_action_t  wr_act,
	input  wire logic                        wr_en,
	input  wire logic                        rd_en,
	output utf8vt_pkg::utf8vt_action_t       rd_act,
	output logic                             q_full,
	output logic                             q_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	utf8vt_pkg::utf8vt_action_t slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full  = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_act  = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_act;
		end
	end

endmodule

`default_nettype wire

### design/utf8vt_back.sv
`default_nettype none

module utf8vt_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire utf8vt_pkg::utf8vt_action_t  q_act,
	input  wire logic                        q_empty,
	output logic                             q_pop,
	input  wire logic                        pop,
	output logic                             empty,
	output utf8vt_pkg::utf8vt_out_t          result
);

	utf8vt_pkg::utf8vt_action_t act_q;
	logic       act_valid_q;
	logic [2:0] idx_q;
	logic       is_byte;
	logic       last_of_act;
	logic       taken;

	// Current result item of the action being worked off.
	assign is_byte     = (idx_q < act_q.nbytes);
	assign last_of_act = is_byte ? ((idx_q + 3'd1 == act_q.nbytes) && !act_q.has_end) : 1'b1;
	assign empty       = !act_valid_q;
	assign taken       = pop && act_valid_q;
	assign q_pop       = !q_empty && (!act_valid_q || (taken && last_of_act));

	always_comb begin
		result.out_byte      = is_byte ? act_q.bytes[idx_q[1:0]] : 8'd0;
		result.has_byte      = is_byte;
		result.end_of_output = !is_byte;
		result.stop_cause    = is_byte ? utf8vt_pkg::CAUSE_KEPT : act_q.cause;
	end

	// Action register and the position within it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else begin
			if (q_pop) begin
				act_valid_q <= 1'b1;
				idx_q       <= 3'd0;
			end else if (taken) begin
				if (last_of_act) begin
					act_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			act_q <= q_act;
		end
	end

endmodule

`default_nettype wire

### design/utf8_validating_truncator_core.sv
`default_nettype none

// UTF-8 validating truncator. The text enters one byte per item on a queue-like
// port (push/full) and each byte is checked for well-formed UTF-8 as it arrives,
// one byte per cycle; complete sequences that fit within the max_bytes limit
// leave whole, one byte per result item on the pop/empty side, and a cut or the
// end of the text gives an end item with a cause code. An input item is checked
// as it is accepted, and its results leave the output one item at a time, so a
// byte that completes a four-byte sequence on the last byte gives five result
// items. A queue of QUEUE_DEPTH actions between the checker and the emitter
// absorbs such bursts; input stalls only when that queue is full. The first
// result of an item passes the action queue and then the action register of the
// emitting side before it is on the output.
// max_bytes is written through cfg_wr_en/cfg_wr_data and resets to 123.
module utf8_validating_truncator_core #(
	parameter int QUEUE_DEPTH = utf8vt_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire utf8vt_pkg::utf8vt_in_t   item,
	input  wire logic                     push,
	output logic                          full,
	output utf8vt_pkg::utf8vt_out_t       result,
	output logic                          empty,
	input  wire logic                     pop,
	input  wire logic                     cfg_wr_en,
	input  wire logic [15:0]              cfg_wr_data
);

	utf8vt_pkg::utf8vt_action_t front_act;
	utf8vt_pkg::utf8vt_action_t head_act;
	logic front_push;
	logic q_full;
	logic q_empty;
	logic q_pop;

	assign full = q_full;

	// Checking side.
	utf8vt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push       (push),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.q_full     (q_full),
		.act        (front_act),
		.act_push   (front_push)
	);

	// Action queue.
	utf8vt_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_act (front_act),
		.wr_en  (front_push),
		.rd_en  (q_pop),
		.rd_act (head_act),
		.q_full (q_full),
		.q_empty(q_empty)
	);

	// Emitting side.
	utf8vt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_act  (head_act),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

`default_nettype wire

### design/utf8vt_checker.sv
`default_nettype none

module utf8vt_checker (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    push,
	input wire logic                    full,
	input wire utf8vt_pkg::utf8vt_out_t result,
	input wire logic                    empty,
	input wire logic                    pop
);

	// A waiting result item holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	// Every result item is either a byte or an end item, never both.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.has_byte != result.end_of_output))
		else $error("result item is neither a byte nor an end");

	// End items carry no byte and a defined cause.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.end_of_output |-> result.out_byte == 8'd0 &&
			(result.stop_cause == utf8vt_pkg::CAUSE_KEPT ||
			 result.stop_cause == utf8vt_pkg::CAUSE_INVALID ||
			 result.stop_cause == utf8vt_pkg::CAUSE_LIMIT))
		else $error("malformed end item");

	// Results reappear only after an accepted item has passed through the action queue and the action register.
	a_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(push && !full, 2))
		else $error("result appeared without an accepted item");

endmodule

bind utf8_validating_truncator_core utf8vt_checker u_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.result(result),
	.empty (empty),
	.pop   (pop)
);

`default_nettype wire
